// File: hdl/pcct_pkg.sv
// Shared types and constants of the point cloud crop and transform block.
// Used by every module under hdl but pcct_fifo; depends on nothing else.
package pcct_pkg;

	// Field widths fixed by the item formats.
	localparam int COORD_BITS     = 24;
	localparam int COEF_BITS      = 16;
	localparam int TRANS_BITS     = 21;
	localparam int RANGE_BITS     = 48;
	localparam int COUNT_BITS     = 20;
	localparam int STRIDE_BITS    = 7;
	localparam int PHASE_BITS     = 6;
	localparam int INTENSITY_BITS = 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 63;
	localparam int ROT_BITS       = 3 * COEF_BITS;
	localparam int MAX_STRIDE     = 64;

	// Queue depths and their level widths.
	localparam int MID_DEPTH      = 8;
	localparam int MID_LEVEL_BITS = $clog2(MID_DEPTH + 1);
	localparam int RQ_DEPTH       = 8;
	localparam int RQ_LEVEL_BITS  = $clog2(RQ_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_X      = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_Y      = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROT_Z      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRANS      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_RANGE  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_RANGE  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_POINTS = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STRIDE     = 3'd7;

	// Record kinds of a result.
	localparam logic REC_POINT = 1'b0;
	localparam logic REC_COUNT = 1'b1;

	typedef struct packed {
		logic                          point_valid;
		logic signed [COORD_BITS-1:0]  x_in;
		logic signed [COORD_BITS-1:0]  y_in;
		logic signed [COORD_BITS-1:0]  z_in;
		logic                          end_of_row;
		logic                          end_of_frame;
	} in_item_t;

	typedef struct packed {
		logic                          record_kind;
		logic signed [COORD_BITS-1:0]  x_out;
		logic signed [COORD_BITS-1:0]  y_out;
		logic signed [COORD_BITS-1:0]  z_out;
		logic [INTENSITY_BITS-1:0]     intensity;
		logic [COUNT_BITS-1:0]         point_count;
		logic                          last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [ROT_BITS-1:0]           rot_x;
		logic [ROT_BITS-1:0]           rot_y;
		logic [ROT_BITS-1:0]           rot_z;
		logic [3*TRANS_BITS-1:0]       trans;
		logic [RANGE_BITS-1:0]         range_floor;
		logic [RANGE_BITS-1:0]         range_ceil;
		logic [COUNT_BITS-1:0]         point_cap;
		logic [STRIDE_BITS-1:0]        sample_step;
	} cfg_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic                          emit_point;
		logic                          end_frame;
		logic [COUNT_BITS-1:0]         count;
		logic signed [COORD_BITS-1:0]  x;
		logic signed [COORD_BITS-1:0]  y;
		logic signed [COORD_BITS-1:0]  z;
	} work_t;

	localparam cfg_t CFG_RESET = '{
		rot_x:       48'd16384,
		rot_y:       48'd1073741824,
		rot_z:       48'd70368744177664,
		trans:       63'd0,
		range_floor: 48'd670761,
		range_ceil:  48'd10485760000,
		point_cap:   20'd20000,
		sample_step: 7'd1
	};

endpackage

// File: hdl/point_cloud_crop_and_transform.sv
// Top level of the point cloud crop and transform block.
// Depends on pcct_pkg, pcct_fifo, pcct_front, pcct_back and pcct_rq.
//
// Usage. Depth points enter row-major through a queue-style port: a point
// transfers at a rising edge with push high and full low. Results leave the
// same way: the oldest result sits on result while empty is low and transfers
// at an edge with pop high. Configuration registers are written through
// cfg_write, cfg_index and cfg_data, one register per cycle, while idle.
//
// Throughput is one point per cycle while full is low. The classifier
// (three stages: magnitude, square, sum and band/cap decision) and the
// transform (three stages: multiply, round, translate) each run without
// stalling; a credit check in front of each keeps the queue behind it from
// overflowing. A point that makes a result passes the classifier stages, the
// middle queue, the transform stages and the result queue to reach result.
// A frame's last point that yields a point gives two results on consecutive pops.
// When the receiver stops popping, the result queue fills, the transform stops
// taking work, the middle queue fills and full rises; nothing is dropped.
// Reset clears the sampling phases, the point count, the cap flag and both
// queues, and loads the default transform, range band, cap and stride.
module point_cloud_crop_and_transform #(
	parameter int POINT_INTENSITY = 255,
	parameter int COEF_FRAC_BITS  = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  pcct_pkg::in_item_t                     point,
	output logic                                   empty,
	input  logic                                   pop,
	output pcct_pkg::out_item_t                    result,
	input  logic                                   cfg_write,
	input  logic [pcct_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [pcct_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int MID_W   = $bits(pcct_pkg::work_t);
	localparam int MLB     = pcct_pkg::MID_LEVEL_BITS;
	localparam int FULL_W  = MLB + 1;

	pcct_pkg::cfg_t                       cfg_q;
	logic                                 accept;
	logic [1:0]                           front_inflight;
	logic                                 mid_push;
	pcct_pkg::work_t                      mid_wr;
	logic [MID_W-1:0]                     mid_rdata;
	pcct_pkg::work_t                      mid_head;
	logic                                 mid_empty;
	logic [MLB-1:0]                       mid_level;
	logic                                 mid_take;
	logic [pcct_pkg::RQ_LEVEL_BITS-1:0]   rq_level;
	logic [1:0]                           rq_push_count;
	pcct_pkg::out_item_t                  rq_wr0;
	pcct_pkg::out_item_t                  rq_wr1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pcct_pkg::CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				pcct_pkg::REG_ROT_X:      cfg_q.rot_x       <= cfg_data[pcct_pkg::ROT_BITS-1:0];
				pcct_pkg::REG_ROT_Y:      cfg_q.rot_y       <= cfg_data[pcct_pkg::ROT_BITS-1:0];
				pcct_pkg::REG_ROT_Z:      cfg_q.rot_z       <= cfg_data[pcct_pkg::ROT_BITS-1:0];
				pcct_pkg::REG_TRANS:      cfg_q.trans       <= cfg_data;
				pcct_pkg::REG_MIN_RANGE:  cfg_q.range_floor <= cfg_data[pcct_pkg::RANGE_BITS-1:0];
				pcct_pkg::REG_MAX_RANGE:  cfg_q.range_ceil  <= cfg_data[pcct_pkg::RANGE_BITS-1:0];
				pcct_pkg::REG_MAX_POINTS: cfg_q.point_cap   <= cfg_data[pcct_pkg::COUNT_BITS-1:0];
				pcct_pkg::REG_STRIDE:     cfg_q.sample_step <= cfg_data[pcct_pkg::STRIDE_BITS-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Every item in the classifier may still need a slot in the middle queue.
	assign full   = (FULL_W'(mid_level) + FULL_W'(front_inflight)) >= FULL_W'(pcct_pkg::MID_DEPTH);
	assign accept = push && !full;

	pcct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.accept    (accept),
		.point     (point),
		.inflight  (front_inflight),
		.work_push (mid_push),
		.work      (mid_wr)
	);

	pcct_fifo #(
		.WIDTH (MID_W),
		.DEPTH (pcct_pkg::MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr),
		.pop    (mid_take),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.level  (mid_level)
	);

	assign mid_head = mid_rdata;

	pcct_back #(
		.POINT_INTENSITY (POINT_INTENSITY),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.mid_empty  (mid_empty),
		.entry      (mid_head),
		.take       (mid_take),
		.rq_level   (rq_level),
		.push_count (rq_push_count),
		.res0       (rq_wr0),
		.res1       (rq_wr1)
	);

	pcct_rq #(
		.DEPTH (pcct_pkg::RQ_DEPTH)
	) u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (rq_push_count),
		.wdata0     (rq_wr0),
		.wdata1     (rq_wr1),
		.pop        (pop),
		.rdata      (result),
		.empty      (empty),
		.level      (rq_level)
	);

	// The classifier credit must keep the middle queue from overflowing.
	a_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> (mid_level < MLB'(pcct_pkg::MID_DEPTH)))
		else $error("middle queue written while full");

	// The transform credit must keep the result queue from overflowing.
	a_rq_room: assert property (@(posedge clk) disable iff (!arst_n)
		(rq_push_count != 2'd0) |->
		((int'(rq_level) + int'(rq_push_count)) <= pcct_pkg::RQ_DEPTH))
		else $error("result queue written beyond its depth");

	// A result that is not the last of its run is followed by its partner.
	a_run_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_of_run) |=> !empty)
		else $error("run split across an empty result queue");

endmodule

// File: hdl/pcct_fifo.sv
// Small flop-based FIFO with one write and one read per cycle.
// Used between the classifier and the transform; depends on nothing else.
module pcct_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             pop,
	output logic [WIDTH-1:0]                 rdata,
	output logic                             empty,
	output logic [$clog2(DEPTH+1)-1:0]       level
);

	localparam int PTR_BITS   = $clog2(DEPTH);
	localparam int LEVEL_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]      mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  do_pop;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		ptr_inc = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign do_pop = pop && (level_q != '0);
	assign empty  = (level_q == '0);
	assign level  = level_q;
	assign rdata  = mem_q[rd_ptr_q];

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			level_q <= level_q + LEVEL_BITS'(push) - LEVEL_BITS'(do_pop);
		end
	end

endmodule

// File: hdl/pcct_front.sv
// Front part: sampling phases, squared range check and point cap.
// Depends on pcct_pkg; feeds classified items into the middle queue.
module pcct_front (
	input  logic               clk,
	input  logic               arst_n,
	input  pcct_pkg::cfg_t     cfg,
	input  logic               accept,
	input  pcct_pkg::in_item_t point,
	output logic [1:0]         inflight,
	output logic               work_push,
	output pcct_pkg::work_t    work
);

	localparam int CB     = pcct_pkg::COORD_BITS;
	localparam int SQ_BITS = 2 * CB;
	localparam int PB     = pcct_pkg::PHASE_BITS;
	localparam int SB     = pcct_pkg::STRIDE_BITS;
	localparam int NB     = pcct_pkg::COUNT_BITS;
	localparam int RB     = pcct_pkg::RANGE_BITS;

	logic [SB-1:0] stride_eff;
	logic [PB-1:0] row_phase_q;
	logic [PB-1:0] col_phase_q;
	logic [SB-1:0] row_inc;
	logic [SB-1:0] col_inc;
	logic [PB-1:0] row_next;
	logic [PB-1:0] col_next;
	logic          keep;

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 keep_s1, keep_s2, keep_s3;
	logic                 eof_s1, eof_s2, eof_s3;
	logic signed [CB-1:0] x_s1, y_s1, z_s1;
	logic signed [CB-1:0] x_s2, y_s2, z_s2;
	logic signed [CB-1:0] x_s3, y_s3, z_s3;
	logic [CB-1:0]        ax_s1, ay_s1, az_s1;
	logic [SQ_BITS-1:0]   sx_s2, sy_s2, sz_s2;
	logic [SQ_BITS-1:0]   r2_s3;

	logic [NB-1:0] count_q;
	logic          cap_reached_q;
	logic [NB-1:0] cap_eff;
	logic [NB-1:0] count_inc;
	logic          in_band;
	logic          emit;

	function automatic logic [CB-1:0] mag(input logic signed [CB-1:0] v);
		mag = v[CB-1] ? CB'(~v + CB'(1)) : CB'(v);
	endfunction

	// A stride of zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		if (cfg.sample_step == '0) begin
			stride_eff = SB'(1);
		end else if (cfg.sample_step > SB'(pcct_pkg::MAX_STRIDE)) begin
			stride_eff = SB'(pcct_pkg::MAX_STRIDE);
		end else begin
			stride_eff = cfg.sample_step;
		end
	end

	// Phase advance; a phase at or above the stride wraps on its next step.
	assign row_inc  = {1'b0, row_phase_q} + SB'(1);
	assign col_inc  = {1'b0, col_phase_q} + SB'(1);
	assign row_next = (row_inc >= stride_eff) ? '0 : row_inc[PB-1:0];
	assign col_next = (col_inc >= stride_eff) ? '0 : col_inc[PB-1:0];
	assign keep     = (row_phase_q == '0) && (col_phase_q == '0) && point.point_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_phase_q <= '0;
			col_phase_q <= '0;
		end else if (accept) begin
			if (point.end_of_frame) begin
				row_phase_q <= '0;
				col_phase_q <= '0;
			end else if (point.end_of_row) begin
				row_phase_q <= row_next;
				col_phase_q <= '0;
			end else begin
				col_phase_q <= col_next;
			end
		end
	end

	// Stage valid bits; this pipeline never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign inflight = 2'(vld_s1) + 2'(vld_s2) + 2'(vld_s3);

	// Stage 1 takes magnitudes, stage 2 squares them, stage 3 sums.
	always_ff @(posedge clk) begin
		keep_s1 <= keep;
		eof_s1  <= point.end_of_frame;
		x_s1    <= point.x_in;
		y_s1    <= point.y_in;
		z_s1    <= point.z_in;
		ax_s1   <= mag(point.x_in);
		ay_s1   <= mag(point.y_in);
		az_s1   <= mag(point.z_in);

		keep_s2 <= keep_s1;
		eof_s2  <= eof_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		z_s2    <= z_s1;
		sx_s2   <= SQ_BITS'(ax_s1) * SQ_BITS'(ax_s1);
		sy_s2   <= SQ_BITS'(ay_s1) * SQ_BITS'(ay_s1);
		sz_s2   <= SQ_BITS'(az_s1) * SQ_BITS'(az_s1);

		keep_s3 <= keep_s2;
		eof_s3  <= eof_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		z_s3    <= z_s2;
		r2_s3   <= sx_s2 + sy_s2 + sz_s2;
	end

	// Band check and cap decision; a cap of zero acts as one.
	assign cap_eff   = (cfg.point_cap == '0) ? NB'(1) : cfg.point_cap;
	assign in_band   = (RB'(r2_s3) >= cfg.range_floor) && (RB'(r2_s3) <= cfg.range_ceil);
	assign emit      = vld_s3 && keep_s3 && in_band && !cap_reached_q && (count_q < cap_eff);
	assign count_inc = count_q + NB'(emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			cap_reached_q <= 1'b0;
		end else if (vld_s3) begin
			if (eof_s3) begin
				count_q       <= '0;
				cap_reached_q <= 1'b0;
			end else if (emit) begin
				count_q       <= count_inc;
				cap_reached_q <= cap_reached_q || (count_inc >= cap_eff);
			end
		end
	end

	// Only items that cause a result travel on.
	assign work_push       = vld_s3 && (emit || eof_s3);
	assign work.emit_point = emit;
	assign work.end_frame  = eof_s3;
	assign work.count      = count_inc;
	assign work.x          = x_s3;
	assign work.y          = y_s3;
	assign work.z          = z_s3;

endmodule

// File: hdl/pcct_back.sv
// Back part: rotation, rounding, translation, saturation and record forming.
// Depends on pcct_pkg; reads the middle queue and writes the result queue.
module pcct_back #(
	parameter int POINT_INTENSITY = 255,
	parameter int COEF_FRAC_BITS  = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pcct_pkg::cfg_t                      cfg,
	input  logic                                mid_empty,
	input  pcct_pkg::work_t                     entry,
	output logic                                take,
	input  logic [pcct_pkg::RQ_LEVEL_BITS-1:0]  rq_level,
	output logic [1:0]                          push_count,
	output pcct_pkg::out_item_t                 res0,
	output pcct_pkg::out_item_t                 res1
);

	localparam int CB        = pcct_pkg::COORD_BITS;
	localparam int KB        = pcct_pkg::COEF_BITS;
	localparam int TB        = pcct_pkg::TRANS_BITS;
	localparam int NB        = pcct_pkg::COUNT_BITS;
	localparam int PROD_BITS = KB + CB;
	localparam int ACC_BITS  = PROD_BITS + 2;
	localparam int V_BITS    = ACC_BITS + 1;
	localparam int CR_BITS   = pcct_pkg::RQ_LEVEL_BITS + 2;
	localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [V_BITS-1:0] SAT_HI = (V_BITS'(1) <<< (CB - 1)) - V_BITS'(1);
	localparam logic signed [V_BITS-1:0] SAT_LO = -SAT_HI - V_BITS'(1);

	logic [pcct_pkg::ROT_BITS-1:0] rows [3];
	logic signed [KB-1:0]          coef [3][3];
	logic signed [CB-1:0]          coord [3];
	logic signed [TB-1:0]          tr [3];
	logic signed [ACC_BITS-1:0]    acc_sum [3];
	logic signed [CB-1:0]          sat [3];

	logic                          vld_s1, vld_s2, vld_s3;
	logic                          emit_s1, emit_s2, emit_s3;
	logic                          eof_s1, eof_s2, eof_s3;
	logic [NB-1:0]                 count_s1, count_s2, count_s3;
	logic signed [PROD_BITS-1:0]   prod_s1 [3][3];
	logic signed [ACC_BITS-1:0]    shift_s2 [3];
	logic signed [V_BITS-1:0]      v_s3 [3];

	logic [2:0]                    reserved;
	logic                          credit_ok;
	pcct_pkg::out_item_t           pt_rec;
	pcct_pkg::out_item_t           cnt_rec;

	// Results already promised to the result queue by items in flight.
	assign reserved = (vld_s1 ? 3'(emit_s1) + 3'(eof_s1) : 3'd0)
		+ (vld_s2 ? 3'(emit_s2) + 3'(eof_s2) : 3'd0)
		+ (vld_s3 ? 3'(emit_s3) + 3'(eof_s3) : 3'd0);
	assign credit_ok = (CR_BITS'(rq_level) + CR_BITS'(reserved) + CR_BITS'(2))
		<= CR_BITS'(pcct_pkg::RQ_DEPTH);
	assign take = !mid_empty && credit_ok;

	// Unpack coefficients, coordinates and offsets.
	assign rows[0]  = cfg.rot_x;
	assign rows[1]  = cfg.rot_y;
	assign rows[2]  = cfg.rot_z;
	assign coord[0] = entry.x;
	assign coord[1] = entry.y;
	assign coord[2] = entry.z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef[r][c] = rows[r][KB*c +: KB];
			end
			tr[r] = cfg.trans[TB*r +: TB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Row sums with round-half-up before the fraction is dropped.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc_sum[r] = ACC_BITS'(prod_s1[r][0]) + ACC_BITS'(prod_s1[r][1])
				+ ACC_BITS'(prod_s1[r][2]) + ROUND;
		end
	end

	// Stage 1 multiplies, stage 2 rounds and shifts, stage 3 translates.
	always_ff @(posedge clk) begin
		emit_s1  <= entry.emit_point;
		eof_s1   <= entry.end_frame;
		count_s1 <= entry.count;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= PROD_BITS'(coef[r][c]) * PROD_BITS'(coord[c]);
			end
		end

		emit_s2  <= emit_s1;
		eof_s2   <= eof_s1;
		count_s2 <= count_s1;
		for (int r = 0; r < 3; r++) begin
			shift_s2[r] <= acc_sum[r] >>> COEF_FRAC_BITS;
		end

		emit_s3  <= emit_s2;
		eof_s3   <= eof_s2;
		count_s3 <= count_s2;
		for (int r = 0; r < 3; r++) begin
			v_s3[r] <= V_BITS'(shift_s2[r]) + V_BITS'(tr[r]);
		end
	end

	// Saturate to the signed coordinate range.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (v_s3[r] > SAT_HI) begin
				sat[r] = {1'b0, {(CB-1){1'b1}}};
			end else if (v_s3[r] < SAT_LO) begin
				sat[r] = {1'b1, {(CB-1){1'b0}}};
			end else begin
				sat[r] = v_s3[r][CB-1:0];
			end
		end
	end

	// Point record and frame count record.
	always_comb begin
		pt_rec.record_kind  = pcct_pkg::REC_POINT;
		pt_rec.x_out        = sat[0];
		pt_rec.y_out        = sat[1];
		pt_rec.z_out        = sat[2];
		pt_rec.intensity    = pcct_pkg::INTENSITY_BITS'(POINT_INTENSITY);
		pt_rec.point_count  = '0;
		pt_rec.last_of_run  = !eof_s3;

		cnt_rec.record_kind = pcct_pkg::REC_COUNT;
		cnt_rec.x_out       = '0;
		cnt_rec.y_out       = '0;
		cnt_rec.z_out       = '0;
		cnt_rec.intensity   = '0;
		cnt_rec.point_count = count_s3;
		cnt_rec.last_of_run = 1'b1;
	end

	assign push_count = vld_s3 ? 2'(emit_s3) + 2'(eof_s3) : 2'd0;
	assign res0       = emit_s3 ? pt_rec : cnt_rec;
	assign res1       = cnt_rec;

endmodule

// File: hdl/pcct_rq.sv
// Result queue: takes up to two results per cycle and hands out one.
// Depends on pcct_pkg for the result type.
module pcct_rq #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_count,
	input  pcct_pkg::out_item_t           wdata0,
	input  pcct_pkg::out_item_t           wdata1,
	input  logic                          pop,
	output pcct_pkg::out_item_t           rdata,
	output logic                          empty,
	output logic [$clog2(DEPTH+1)-1:0]    level
);

	localparam int PTR_BITS   = $clog2(DEPTH);
	localparam int LEVEL_BITS = $clog2(DEPTH + 1);

	pcct_pkg::out_item_t   mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [PTR_BITS-1:0]   wr_ptr1;
	logic [PTR_BITS-1:0]   wr_ptr2;
	logic                  do_pop;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		ptr_inc = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign wr_ptr1 = ptr_inc(wr_ptr_q);
	assign wr_ptr2 = ptr_inc(wr_ptr1);
	assign do_pop  = pop && (level_q != '0);
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rdata   = mem_q[rd_ptr_q];

	// The first result goes to the tail, a second one right behind it.
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= wdata0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr1] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			case (push_count)
				2'd1: wr_ptr_q <= wr_ptr1;
				2'd2: wr_ptr_q <= wr_ptr2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			level_q <= level_q + LEVEL_BITS'(push_count) - LEVEL_BITS'(do_pop);
		end
	end

endmodule
